// ----- hw/rtl/mte_pkg.sv -----
// Package with shared types, codes and encoding helpers for the track encoder.
`timescale 1ns / 1ps
`default_nettype none
package mte_pkg;

   // Character limit per track, JIS start code included.
   localparam int unsigned MAX_CHARS = 128;

   // Depth of the packet queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Fixed code constants.
   localparam logic [7:0] JIS_MARK    = 8'h7F;
   localparam logic [7:0] T1_BASE     = 8'h20;
   localparam logic [7:0] T1_TOP      = 8'h5F;
   localparam logic [7:0] T23_BASE    = 8'h30;
   localparam logic [7:0] T23_TOP     = 8'h3F;
   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;

   // Item operation codes.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_FINISH = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   // Track mode register values.
   typedef enum logic [1:0] {
      MODE_TRACK1 = 2'd0,
      MODE_TRACK2 = 2'd1,
      MODE_TRACK3 = 2'd2,
      MODE_JIS2   = 2'd3
   } mode_type;

   localparam logic [1:0] MODE_RESET = MODE_TRACK2;

   // One queue entry: one or two code words from a single item.
   typedef struct packed {
      logic [7:0] word0;
      logic [7:0] word1;
      logic       two;
      logic       last;
   } pkt_type;

   // Put the parity bit of the mode on top of an 8-bit value.
   function automatic logic [7:0] add_parity(input logic [7:0] v, input logic [1:0] mode);
      logic [7:0] r;
      r = v;
      case (mode)
         MODE_TRACK1: r[6] = v[6] | ~(^v[5:0]);
         MODE_JIS2:   r[7] = v[7] | (^v[6:0]);
         default:     r[4] = v[4] | ~(^v[3:0]);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mte_if.sv -----
// Channel interfaces for the request, result and configuration ports.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation item.
interface mte_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] char_in;
   modport source (output valid, output op, output char_in, input ready);
   modport sink   (input valid, input op, input char_in, output ready);
endinterface

// Result channel: one code word item.
interface mte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_word;
   logic       is_last;
   modport source (output valid, output code_word, output is_last, input ready);
   modport sink   (input valid, input code_word, input is_last, output ready);
endinterface

// Configuration write channel for the track mode register.
interface mte_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] track_mode;
   modport source (output valid, output track_mode, input ready);
   modport sink   (input valid, input track_mode, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mte_front.sv -----
// Front end: accepts items, encodes characters and keeps count, LRC and mode.
`timescale 1ns / 1ps
`default_nettype none
module mte_front
   import mte_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mte_req_if.sink     req_chan,
   mte_csr_if.sink     csr_chan,
   input  wire logic   queue_full,
   output logic        push_valid,
   output pkt_type     push_pkt
);

   logic [1:0] mode_ff, mode_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] lrc_ff, lrc_in;
   logic       finished_ff, finished_in;

   logic       accept;
   logic [7:0] c_fold;
   logic [7:0] t1_off;
   logic [7:0] t23_off;
   logic [7:0] word;
   logic       char_ok;
   logic [7:0] lrc_fin;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = ~queue_full;
   assign accept         = req_chan.valid & ~queue_full;

   // Character encoding for the mode in force.
   always_comb begin
      c_fold  = req_chan.char_in;
      if (req_chan.char_in >= LOWER_FIRST && req_chan.char_in <= LOWER_LAST) begin
         c_fold = req_chan.char_in - T1_BASE;
      end
      t1_off  = c_fold - T1_BASE;
      t23_off = req_chan.char_in - T23_BASE;
      char_ok = 1'b1;
      word    = 8'h00;
      unique case (mode_ff)
         MODE_TRACK1: begin
            char_ok = (c_fold >= T1_BASE) && (c_fold <= T1_TOP);
            word    = add_parity({2'b00, t1_off[5:0]}, mode_ff);
         end
         MODE_JIS2: begin
            word = add_parity(req_chan.char_in, mode_ff);
         end
         default: begin
            char_ok = (req_chan.char_in >= T23_BASE) && (req_chan.char_in <= T23_TOP);
            word    = add_parity({4'h0, t23_off[3:0]}, mode_ff);
         end
      endcase
   end

   // Item handling and state update.
   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      lrc_in      = lrc_ff;
      finished_in = finished_ff;
      push_valid  = 1'b0;
      push_pkt    = '{word0: word, word1: word, two: 1'b0, last: 1'b0};
      lrc_fin     = lrc_ff;
      if (csr_chan.valid) begin
         mode_in = csr_chan.track_mode;
      end
      if (accept) begin
         case (req_chan.op)
            OP_CLEAR: begin
               count_in    = 8'd0;
               lrc_in      = 8'd0;
               finished_in = 1'b0;
            end
            OP_ADD: begin
               if (!finished_ff && count_ff < 8'(MAX_CHARS) && char_ok) begin
                  push_valid = 1'b1;
                  lrc_in     = lrc_ff ^ word;
                  count_in   = count_ff + 8'd1;
                  if (mode_ff == MODE_JIS2 && count_ff == 8'd0) begin
                     // First JIS character is preceded by the start code.
                     push_pkt = '{word0: add_parity(JIS_MARK, mode_ff), word1: word,
                                  two: 1'b1, last: 1'b0};
                     count_in = 8'd2;
                  end
               end
            end
            OP_FINISH: begin
               if (!finished_ff) begin
                  finished_in = 1'b1;
                  push_valid  = 1'b1;
                  if (mode_ff == MODE_JIS2) begin
                     // End code enters the LRC unless it sits at the start position.
                     if (count_ff != 8'd0) begin
                        lrc_fin = lrc_ff ^ add_parity(JIS_MARK, mode_ff);
                     end
                     push_pkt = '{word0: add_parity(JIS_MARK, mode_ff),
                                  word1: add_parity(lrc_fin, mode_ff),
                                  two: 1'b1, last: 1'b1};
                  end else begin
                     push_pkt = '{word0: add_parity(lrc_ff, mode_ff), word1: 8'h00,
                                  two: 1'b0, last: 1'b1};
                  end
                  lrc_in = lrc_fin;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RESET;
         count_ff    <= 8'd0;
         lrc_ff      <= 8'd0;
         finished_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         lrc_ff      <= lrc_in;
         finished_ff <= finished_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mte_queue.sv -----
// Short packet queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module mte_queue
   import mte_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire pkt_type  push_pkt,
   input  wire logic     pop,
   output pkt_type       head_pkt,
   output logic          empty,
   output logic          full
);

   pkt_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_pkt = slot_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mte_back.sv -----
// Output stage: splits queued packets into single code word items.
`timescale 1ns / 1ps
`default_nettype none
module mte_back
   import mte_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire pkt_type  head_pkt,
   input  wire logic     empty,
   output logic          pop,
   mte_rsp_if.source     rsp_chan
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_word_ff, out_word_in;
   logic       out_last_ff, out_last_in;
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_word_ff, hold_word_in;
   logic       hold_last_ff, hold_last_in;
   logic       advance;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.code_word = out_word_ff;
   assign rsp_chan.is_last   = out_last_ff;
   assign advance            = ~out_valid_ff | rsp_chan.ready;

   // Load the output register from the held second word or the queue head.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      out_last_in   = out_last_ff;
      hold_valid_in = hold_valid_ff;
      hold_word_in  = hold_word_ff;
      hold_last_in  = hold_last_ff;
      pop           = 1'b0;
      if (advance) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = hold_word_ff;
            out_last_in   = hold_last_ff;
            hold_valid_in = 1'b0;
         end else if (!empty) begin
            pop           = 1'b1;
            out_valid_in  = 1'b1;
            out_word_in   = head_pkt.word0;
            out_last_in   = head_pkt.last & ~head_pkt.two;
            hold_valid_in = head_pkt.two;
            hold_word_in  = head_pkt.word1;
            hold_last_in  = head_pkt.last;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      out_last_ff  <= out_last_in;
      hold_word_ff <= hold_word_in;
      hold_last_ff <= hold_last_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/magstripe_track_char_encoder.sv -----
// Top level of the magnetic stripe track character encoder.
//
//   Port      Dir   Moves                        Accepted when
//   req_chan  in    op, char_in                  valid && ready
//   rsp_chan  out   code_word, is_last           valid && ready
//   csr_chan  in    track_mode write data        valid && ready (ready stays high)
//
// The front end takes one item per cycle while the queue is not full; each result
// passes through the two-entry packet queue and then the output register.
// The output stage gives one code word per cycle while the result port is ready,
// so an item that yields two words (first JIS character, JIS finish) sends both in turn.
// Reset is synchronous: mode goes to track 2, count, LRC and finished clear.
// A stalled result port fills the queue, and then request ready drops.
`timescale 1ns / 1ps
`default_nettype none
module magstripe_track_char_encoder
   import mte_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mte_req_if.sink   req_chan,
   mte_rsp_if.source rsp_chan,
   mte_csr_if.sink   csr_chan
);

   logic    push_valid;
   pkt_type push_pkt;
   pkt_type head_pkt;
   logic    pop;
   logic    empty;
   logic    full;

   // Item intake and encoding.
   mte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (full),
      .push_valid (push_valid),
      .push_pkt   (push_pkt)
   );

   // Decoupling queue.
   mte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_pkt   (push_pkt),
      .pop        (pop),
      .head_pkt   (head_pkt),
      .empty      (empty),
      .full       (full)
   );

   // Result delivery.
   mte_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_pkt (head_pkt),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
